/* sv/ipap_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IP address parser package
// Shared character codes, result kinds and the result types that the two
// recognizers hand to the top level.
// ----------------------------------------------------------------------------
package ipap_pkg;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;

   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_IPV4    = 2'd1,
      KIND_IPV6    = 2'd2
   } addr_kind_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] addr;
   } v4_res_type;

   typedef struct packed {
      logic         ok;
      logic [127:0] addr;
   } v6_res_type;

   // Eight 16-bit groups, element 0 is the most significant group.
   typedef logic [7:0][15:0] grp_arr_type;

endpackage
`default_nettype wire

/* sv/ipap_v4_parse.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 dotted-decimal recognizer
// Holds the IPv4 parsing state, advances it by one character per fire and
// reports the finished address for the string that ends with this character.
// ----------------------------------------------------------------------------
module ipap_v4_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          ch,
   input  wire logic                fire,
   input  wire logic                last,
   output ipap_pkg::v4_res_type     result
);
   import ipap_pkg::*;

   logic [31:0] parts_ff, parts_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [8:0]  val_ff, val_in;
   logic        digit_ff, digit_in;
   logic        err_ff, err_in;
   logic        done_ff, done_in;

   logic        is_digit;
   logic [3:0]  digit_val;
   logic [11:0] prod;

   assign is_digit  = (ch >= CHAR_0) && (ch <= CHAR_9);
   assign digit_val = 4'(ch - CHAR_0);
   assign prod      = 12'({3'b000, val_ff} * 12'd10) + {8'h00, digit_val};

   always_comb begin
      parts_in = parts_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      digit_in = digit_ff;
      err_in   = err_ff;
      done_in  = done_ff;
      if (!err_ff) begin
         if (is_digit) begin
            if (done_ff) begin
               err_in = 1'b1;
            end else begin
               // The part value saturates at 256, which is already out of range.
               val_in   = (prod > 12'd256) ? 9'd256 : prod[8:0];
               digit_in = 1'b1;
            end
         end else if (ch == CHAR_DOT) begin
            if (done_ff || !digit_ff || (val_ff > 9'd255) || (cnt_ff >= 3'd4)) begin
               err_in = 1'b1;
            end else begin
               parts_in = {parts_ff[23:0], val_ff[7:0]};
               cnt_in   = cnt_ff + 3'd1;
               val_in   = '0;
               digit_in = 1'b0;
               done_in  = (cnt_ff == 3'd3);
            end
         end else begin
            err_in = 1'b1;
         end
      end
   end

   always_comb begin
      result.ok   = !err_in && (done_in ||
                    ((cnt_in == 3'd3) && digit_in && (val_in <= 9'd255)));
      result.addr = done_in ? parts_in : {parts_in[23:0], val_in[7:0]};
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && last)) begin
         parts_ff <= '0;
         cnt_ff   <= '0;
         val_ff   <= '0;
         digit_ff <= 1'b0;
         err_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else if (fire) begin
         parts_ff <= parts_in;
         cnt_ff   <= cnt_in;
         val_ff   <= val_in;
         digit_ff <= digit_in;
         err_ff   <= err_in;
         done_ff  <= done_in;
      end
   end

endmodule
`default_nettype wire

/* sv/ipap_v6_parse.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 colon-hex recognizer
// Places each finished group directly in its final slot: groups before the
// zero run fill slots from the top, groups after it shift in from the bottom.
// ----------------------------------------------------------------------------
module ipap_v6_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          ch,
   input  wire logic                fire,
   input  wire logic                last,
   output ipap_pkg::v6_res_type     result
);
   import ipap_pkg::*;

   grp_arr_type groups_ff, groups_in;
   logic [3:0]  gcnt_ff, gcnt_in;
   logic [3:0]  spos_ff, spos_in;
   logic [15:0] val_ff, val_in;
   logic [2:0]  dcnt_ff, dcnt_in;
   logic        split_ff, split_in;
   logic        colon_ff, colon_in;
   logic        err_ff, err_in;
   logic        lead_ff, lead_in;

   logic        hex_ok;
   logic [3:0]  hex_d;
   grp_arr_type fin_groups;
   logic [3:0]  fin_gcnt;
   logic        fin_ok;

   // Before the zero run a group goes to the slot of its own number; after
   // it the tail region shifts down by one and the group enters the last slot.
   function automatic grp_arr_type place_group(grp_arr_type g, logic split,
                                               logic [3:0] spos, logic [3:0] gcnt,
                                               logic [15:0] v);
      grp_arr_type r;
      grp_arr_type shifted;
      r       = g;
      shifted = {v, g[7:1]};
      for (int j = 0; j < 8; j++) begin
         if (split) begin
            if (4'(j) >= spos) r[j] = shifted[j];
         end else if (gcnt[2:0] == 3'(j)) begin
            r[j] = v;
         end
      end
      return r;
   endfunction

   always_comb begin
      hex_ok = 1'b1;
      hex_d  = '0;
      if ((ch >= CHAR_0) && (ch <= CHAR_9)) begin
         hex_d = 4'(ch - CHAR_0);
      end else if ((ch >= CHAR_LO_A) && (ch <= CHAR_LO_F)) begin
         hex_d = 4'(ch - CHAR_LO_A + 8'd10);
      end else if ((ch >= CHAR_UP_A) && (ch <= CHAR_UP_F)) begin
         hex_d = 4'(ch - CHAR_UP_A + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      groups_in = groups_ff;
      gcnt_in   = gcnt_ff;
      spos_in   = spos_ff;
      val_in    = val_ff;
      dcnt_in   = dcnt_ff;
      split_in  = split_ff;
      colon_in  = colon_ff;
      err_in    = err_ff;
      lead_in   = lead_ff;
      if (!err_ff) begin
         if (ch == CHAR_COLON) begin
            if (dcnt_ff != 3'd0) begin
               if (gcnt_ff >= 4'd8) begin
                  err_in = 1'b1;
               end else begin
                  groups_in = place_group(groups_ff, split_ff, spos_ff, gcnt_ff, val_ff);
                  gcnt_in   = gcnt_ff + 4'd1;
                  val_in    = '0;
                  dcnt_in   = '0;
               end
               colon_in = 1'b1;
            end else if (colon_ff) begin
               if (split_ff) begin
                  err_in = 1'b1;
               end else begin
                  split_in = 1'b1;
                  lead_in  = 1'b0;
                  spos_in  = gcnt_ff;
               end
            end else begin
               colon_in = 1'b1;
               lead_in  = 1'b1;
            end
         end else if (!hex_ok || (dcnt_ff >= 3'd4) || lead_ff) begin
            err_in = 1'b1;
         end else begin
            val_in   = {val_ff[11:0], hex_d};
            dcnt_in  = dcnt_ff + 3'd1;
            colon_in = 1'b0;
         end
      end
   end

   // End of string: close a pending group, then check the group count.
   always_comb begin
      fin_groups = groups_in;
      fin_gcnt   = gcnt_in;
      fin_ok     = !err_in;
      if (colon_in) begin
         if (!split_in || (spos_in != gcnt_in)) fin_ok = 1'b0;
      end else if (dcnt_in != 3'd0) begin
         if (gcnt_in >= 4'd8) begin
            fin_ok = 1'b0;
         end else begin
            fin_groups = place_group(groups_in, split_in, spos_in, gcnt_in, val_in);
            fin_gcnt   = gcnt_in + 4'd1;
         end
      end
      if (split_in ? (fin_gcnt > 4'd7) : (fin_gcnt != 4'd8)) fin_ok = 1'b0;
      result.ok   = fin_ok;
      result.addr = {fin_groups[0], fin_groups[1], fin_groups[2], fin_groups[3],
                     fin_groups[4], fin_groups[5], fin_groups[6], fin_groups[7]};
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && last)) begin
         groups_ff <= '0;
         gcnt_ff   <= '0;
         spos_ff   <= '0;
         val_ff    <= '0;
         dcnt_ff   <= '0;
         split_ff  <= 1'b0;
         colon_ff  <= 1'b0;
         err_ff    <= 1'b0;
         lead_ff   <= 1'b0;
      end else if (fire) begin
         groups_ff <= groups_in;
         gcnt_ff   <= gcnt_in;
         spos_ff   <= spos_in;
         val_ff    <= val_in;
         dcnt_ff   <= dcnt_in;
         split_ff  <= split_in;
         colon_ff  <= colon_in;
         err_ff    <= err_in;
         lead_ff   <= lead_in;
      end
   end

endmodule
`default_nettype wire

/* sv/ip_address_text_parser.sv */
// The parser takes an address string one character per cycle and returns
// one word per string, on its last character, of kind IPv4, IPv6 or
// invalid, with the 128-bit address. A new character is taken in every
// cycle unless a last character is waiting; the last character of a
// string is held in the input register and its result in the result
// register. The only stall comes from the result register: a last
// character waits in the input register while an earlier result is still
// held there, and characters that are not last keep flowing through.
// Both recognizers update their state from the registered character in a
// single pass of small logic. IPv4 wins over IPv6 when both succeed; for an
// IPv4 result the four bytes sit in bits 63 to 32 of the high half.
`default_nettype none
// ----------------------------------------------------------------------------
// IP address text parser
// Top level: input register, IPv4 and IPv6 recognizers, result register.
// ----------------------------------------------------------------------------
module ip_address_text_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_addr_kind,
   output logic [63:0]      rsp_addr_high,
   output logic [63:0]      rsp_addr_low
);
   import ipap_pkg::*;

   // Input register.
   logic          in_valid_ff;
   logic [7:0]    in_ch_ff;
   logic          in_last_ff;

   // Result register.
   logic          out_valid_ff;
   addr_kind_type kind_ff, kind_in;
   logic [63:0]   high_ff, high_in;
   logic [63:0]   low_ff, low_in;

   logic          proc_fire;
   logic          out_free;
   v4_res_type    v4_res;
   v6_res_type    v6_res;

   // A character that is not last produces nothing and can always move on.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign proc_fire = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || proc_fire;

   ipap_v4_parse u_v4 (
      .clock  (clock),
      .reset  (reset),
      .ch     (in_ch_ff),
      .fire   (proc_fire),
      .last   (in_last_ff),
      .result (v4_res)
   );

   ipap_v6_parse u_v6 (
      .clock  (clock),
      .reset  (reset),
      .ch     (in_ch_ff),
      .fire   (proc_fire),
      .last   (in_last_ff),
      .result (v6_res)
   );

   // IPv4 takes priority; an invalid string reports an all-zero address.
   always_comb begin
      if (v4_res.ok) begin
         kind_in = KIND_IPV4;
         high_in = {v4_res.addr, 32'h0000_0000};
         low_in  = '0;
      end else if (v6_res.ok) begin
         kind_in = KIND_IPV6;
         high_in = v6_res.addr[127:64];
         low_in  = v6_res.addr[63:0];
      end else begin
         kind_in = KIND_INVALID;
         high_in = '0;
         low_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_fire && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && in_last_ff) begin
         kind_ff <= kind_in;
         high_ff <= high_in;
         low_ff  <= low_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_addr_kind = kind_ff;
   assign rsp_addr_high = high_ff;
   assign rsp_addr_low  = low_ff;

   // A processed last character always leaves a word in the result register.
   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && in_last_ff) |=> out_valid_ff)
      else $error("last character did not produce a result word");

   // A last character never overwrites a word that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !(proc_fire && in_last_ff))
      else $error("result word overwritten while stalled");

   // An IPv4 word carries nothing below the top 32 bits.
   a_v4_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (kind_ff == KIND_IPV4)) |-> ((low_ff == '0) && (high_ff[31:0] == '0)))
      else $error("IPv4 result has bits outside the top 32");

   // An invalid word carries an all-zero address.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (kind_ff == KIND_INVALID)) |-> ((low_ff == '0) && (high_ff == '0)))
      else $error("invalid result has a nonzero address");

   // An empty input register always takes a character.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input register empty but not ready");

endmodule
`default_nettype wire
